[rtl/env_sensor_compensation_macros.svh]
// ----------------------------------------------------------------------------
// Environmental sensor compensation: assertion macros
// Shared property forms for the checker of the compensation block.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("esc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("esc check failed");

`endif

[rtl/esc_pkg.sv]
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Command codes, register indexes and shift helpers shared by the block.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam logic [1:0] CMD_TEMP  = 2'd0;
    localparam logic [1:0] CMD_PRESS = 2'd1;
    localparam logic [1:0] CMD_HUM   = 2'd2;

    localparam logic [2:0] REG_TEMP     = 3'd0;
    localparam logic [2:0] REG_PRESS_A  = 3'd1;
    localparam logic [2:0] REG_PRESS_B  = 3'd2;
    localparam logic [2:0] REG_PRESS_10 = 3'd3;
    localparam logic [2:0] REG_HUM      = 3'd4;

    typedef enum logic [1:0] {
        OP_ALU,
        OP_MUL,
        OP_DIV
    } op_kind_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
        logic signed [31:0] s;
        s = $signed(x);
        return 32'(s >>> n);
    endfunction

    function automatic logic [31:0] asr64(input logic [63:0] x, input logic [5:0] n);
        logic signed [63:0] s;
        s = $signed(x);
        return 32'(s >>> n);
    endfunction

endpackage

[rtl/esc_mul.sv]
// ----------------------------------------------------------------------------
// Serial signed multiplier
// Forms the 64-bit product of two signed 32-bit operands, one multiplier
// bit per cycle.
// ----------------------------------------------------------------------------
module esc_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [63:0] product
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] addend;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        addend      = mplier_reg[0] ? mcand_reg : 64'd0;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = 5'd0;
            mcand_next  = {{32{op_a[31]}}, op_a};
            mplier_next = op_b;
            acc_next    = 64'd0;
        end else if (busy_reg) begin
            // The top multiplier bit carries negative weight.
            acc_next    = (cnt_reg == 5'd31) ? acc_reg - addend : acc_reg + addend;
            mcand_next  = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/esc_div.sv]
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of 32-bit signed operands, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module esc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_trial;
    logic        fits;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        rem_trial = {rem_reg, quo_reg[31]};
        fits      = rem_trial >= {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            neg_next  = op_a[31] ^ op_b[31];
            den_next  = op_b[31] ? 32'd0 - op_b : op_b;
            quo_next  = op_a[31] ? 32'd0 - op_a : op_a;
            rem_next  = 32'd0;
        end else if (busy_reg) begin
            rem_next = fits ? 32'(rem_trial - {1'b0, den_reg}) : rem_trial[31:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 32'd0 - quo_reg : quo_reg;

endmodule

[rtl/env_sensor_compensation.sv]
// Each multiply or divide step runs in the shared serial multiplier or divider.
// One item is in work at a time: the next input transfer is taken in the cycle after the
// previous result is loaded, and a result still held at the output stalls the last step.
// Reset (synchronous, active low) clears the coefficients, the fine temperature and all handshake state.
// ----------------------------------------------------------------------------
// Environmental sensor compensation
// Integer temperature, pressure and humidity compensation run by a step
// sequencer over a shared serial multiplier and divider.
// ----------------------------------------------------------------------------
module env_sensor_compensation import esc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [19:0]        s_raw_adc,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [32:0] m_value,
    output logic               m_divide_fault,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [19:0] adc_reg, adc_next;
    logic [31:0] fine_reg, fine_next;
    logic [31:0] ra_reg, ra_next, rb_reg, rb_next, rc_reg, rc_next;
    logic [31:0] rd_reg, rd_next, re_reg, re_next;
    logic        big_reg, big_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [32:0] m_value_reg, m_value_next;
    logic        m_fault_reg, m_fault_next;

    logic [39:0] temp_coeffs_reg;
    logic [55:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [7:0]  press_ten_reg;
    logic [63:0] hum_coeffs_reg;
    logic [2:0]  cfg_index;

    op_kind_t    op;
    logic        fin, commit, out_free;
    logic        res_fault;
    logic [32:0] res_value;
    logic [31:0] wb_fine, wb_a, wb_b, wb_c, wb_d, wb_e;
    logic        wb_big;
    logic [31:0] mul_a, mul_b, div_a, div_b, quo, lo, scaled;
    logic [63:0] prod;
    logic        mul_start, div_start, mul_done, div_done;

    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    logic [31:0] h1, h2, h3, h4, h5, h6, h7;

    assign t1  = {16'd0, temp_coeffs_reg[15:0]};
    assign t2  = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
    assign t3  = {{24{temp_coeffs_reg[39]}}, temp_coeffs_reg[39:32]};
    assign p1  = {16'd0, press_a_reg[15:0]};
    assign p2  = {{16{press_a_reg[31]}}, press_a_reg[31:16]};
    assign p3  = {{24{press_a_reg[39]}}, press_a_reg[39:32]};
    assign p4  = {{16{press_a_reg[55]}}, press_a_reg[55:40]};
    assign p5  = {{16{press_b_reg[15]}}, press_b_reg[15:0]};
    assign p6  = {{24{press_b_reg[23]}}, press_b_reg[23:16]};
    assign p7  = {{24{press_b_reg[31]}}, press_b_reg[31:24]};
    assign p8  = {{16{press_b_reg[47]}}, press_b_reg[47:32]};
    assign p9  = {{16{press_b_reg[63]}}, press_b_reg[63:48]};
    assign p10 = {24'd0, press_ten_reg};
    assign h1  = {20'd0, hum_coeffs_reg[11:0]};
    assign h2  = {20'd0, hum_coeffs_reg[23:12]};
    assign h3  = {{24{hum_coeffs_reg[31]}}, hum_coeffs_reg[31:24]};
    assign h4  = {{24{hum_coeffs_reg[39]}}, hum_coeffs_reg[39:32]};
    assign h5  = {{24{hum_coeffs_reg[47]}}, hum_coeffs_reg[47:40]};
    assign h6  = {24'd0, hum_coeffs_reg[55:48]};
    assign h7  = {{24{hum_coeffs_reg[63]}}, hum_coeffs_reg[63:56]};

    assign lo     = prod[31:0];
    assign scaled = asr32((fine_reg << 2) + fine_reg + 32'd128, 6'd8);

    esc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    esc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .op_a     (div_a),
        .op_b     (div_b),
        .done     (div_done),
        .quotient (quo)
    );

    // Step program: operands for the shared units and the write-back of each step.
    always_comb begin
        op        = OP_ALU;
        fin       = 1'b0;
        res_fault = 1'b0;
        res_value = 33'd0;
        mul_a     = ra_reg;
        mul_b     = rb_reg;
        div_a     = rb_reg;
        div_b     = 32'd100;
        wb_fine   = fine_reg;
        wb_a      = ra_reg;
        wb_b      = rb_reg;
        wb_c      = rc_reg;
        wb_d      = rd_reg;
        wb_e      = re_reg;
        wb_big    = big_reg;
        case (cmd_reg)
            CMD_TEMP: begin
                case (step_reg)
                    5'd0: wb_a = {15'd0, adc_reg[19:3]} - {15'd0, t1[15:0], 1'b0};
                    5'd1: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = t2;
                        wb_b = asr64(prod, 6'd11);
                    end
                    5'd2: wb_c = asr32(ra_reg, 6'd1);
                    5'd3: begin
                        op = OP_MUL; mul_a = rc_reg; mul_b = rc_reg;
                        wb_c = asr64(prod, 6'd12);
                    end
                    5'd4: begin
                        op = OP_MUL; mul_a = rc_reg; mul_b = t3 << 4;
                        wb_c = asr64(prod, 6'd14);
                    end
                    5'd5: wb_fine = rb_reg + rc_reg;
                    default: begin
                        fin       = 1'b1;
                        res_value = {{17{scaled[15]}}, scaled[15:0]};
                    end
                endcase
            end
            CMD_PRESS: begin
                case (step_reg)
                    5'd0:  wb_a = asr32(fine_reg, 6'd1) - 32'd64000;
                    5'd1:  wb_b = asr32(ra_reg, 6'd2);
                    5'd2: begin
                        op = OP_MUL; mul_a = rb_reg; mul_b = rb_reg;
                        wb_c = asr32(lo, 6'd11);
                    end
                    5'd3: begin
                        op = OP_MUL; mul_a = rc_reg; mul_b = p6;
                        wb_c = asr32(lo, 6'd2);
                    end
                    5'd4: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = p5;
                        wb_c = rc_reg + (lo << 1);
                    end
                    5'd5:  wb_c = asr32(rc_reg, 6'd2) + (p4 << 16);
                    5'd6: begin
                        op = OP_MUL; mul_a = rb_reg; mul_b = rb_reg;
                        wb_d = asr32(lo, 6'd13);
                    end
                    5'd7: begin
                        op = OP_MUL; mul_a = rd_reg; mul_b = p3 << 5;
                        wb_d = asr32(lo, 6'd3);
                    end
                    5'd8: begin
                        op = OP_MUL; mul_a = p2; mul_b = ra_reg;
                        wb_d = rd_reg + asr32(lo, 6'd1);
                    end
                    5'd9:  wb_d = asr32(rd_reg, 6'd18) + 32'd32768;
                    5'd10: begin
                        op = OP_MUL; mul_a = rd_reg; mul_b = p1;
                        wb_d = asr32(lo, 6'd15);
                    end
                    5'd11: wb_e = 32'd1048576 - {12'd0, adc_reg} - asr32(rc_reg, 6'd12);
                    5'd12: begin
                        op = OP_MUL; mul_a = re_reg; mul_b = 32'd3125;
                        wb_e = lo;
                    end
                    5'd13: begin
                        if (rd_reg == 32'd0) begin
                            fin       = 1'b1;
                            res_fault = 1'b1;
                        end else begin
                            wb_big = $signed(re_reg) >= $signed(32'h4000_0000);
                            wb_e   = wb_big ? re_reg : re_reg << 1;
                        end
                    end
                    5'd14: begin
                        op = OP_DIV; div_a = re_reg; div_b = rd_reg;
                        wb_e = big_reg ? quo << 1 : quo;
                    end
                    5'd15: wb_b = asr32(re_reg, 6'd3);
                    5'd16: begin
                        op = OP_MUL; mul_a = rb_reg; mul_b = rb_reg;
                        wb_b = asr32(lo, 6'd13);
                    end
                    5'd17: begin
                        op = OP_MUL; mul_a = p9; mul_b = rb_reg;
                        wb_a = asr32(lo, 6'd12);
                    end
                    5'd18: wb_b = asr32(re_reg, 6'd2);
                    5'd19: begin
                        op = OP_MUL; mul_a = rb_reg; mul_b = p8;
                        wb_b = asr32(lo, 6'd13);
                    end
                    5'd20: begin
                        wb_a = ra_reg + rb_reg;
                        wb_c = asr32(re_reg, 6'd8);
                    end
                    5'd21: begin
                        op = OP_MUL; mul_a = rc_reg; mul_b = rc_reg;
                        wb_d = lo;
                    end
                    5'd22: begin
                        op = OP_MUL; mul_a = rd_reg; mul_b = rc_reg;
                        wb_d = lo;
                    end
                    5'd23: begin
                        op = OP_MUL; mul_a = rd_reg; mul_b = p10;
                        wb_d = asr32(lo, 6'd17);
                    end
                    default: begin
                        fin       = 1'b1;
                        res_value = {1'b0, re_reg
                                     + asr32(ra_reg + rd_reg + (p7 << 7), 6'd4)};
                    end
                endcase
            end
            CMD_HUM: begin
                case (step_reg)
                    5'd0:  wb_a = scaled;
                    5'd1: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = h3;
                        wb_b = lo;
                    end
                    5'd2: begin
                        op = OP_DIV; div_a = rb_reg;
                        wb_b = quo;
                    end
                    5'd3:  wb_b = {16'd0, adc_reg[15:0]} - {16'd0, h1[11:0], 4'd0}
                                  - asr32(rb_reg, 6'd1);
                    5'd4: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = h4;
                        wb_c = lo;
                    end
                    5'd5: begin
                        op = OP_DIV; div_a = rc_reg;
                        wb_c = quo;
                    end
                    5'd6: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = h5;
                        wb_d = lo;
                    end
                    5'd7: begin
                        op = OP_DIV; div_a = rd_reg;
                        wb_d = quo;
                    end
                    5'd8: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = rd_reg;
                        wb_d = asr32(lo, 6'd6);
                    end
                    5'd9: begin
                        op = OP_DIV; div_a = rd_reg;
                        wb_d = quo;
                    end
                    5'd10: wb_c = rc_reg + rd_reg + 32'd16384;
                    5'd11: begin
                        op = OP_MUL; mul_a = h2; mul_b = rc_reg;
                        wb_c = asr32(lo, 6'd10);
                    end
                    5'd12: begin
                        op = OP_MUL; mul_a = rb_reg; mul_b = rc_reg;
                        wb_b = lo;
                    end
                    5'd13: begin
                        op = OP_MUL; mul_a = ra_reg; mul_b = h7;
                        wb_c = lo;
                    end
                    5'd14: begin
                        op = OP_DIV; div_a = rc_reg;
                        wb_c = quo;
                    end
                    5'd15: begin
                        wb_c = asr32((h6 << 7) + rc_reg, 6'd4);
                        wb_d = asr32(rb_reg, 6'd14);
                    end
                    5'd16: begin
                        op = OP_MUL; mul_a = rd_reg; mul_b = rd_reg;
                        wb_d = asr32(lo, 6'd10);
                    end
                    5'd17: begin
                        op = OP_MUL; mul_a = rc_reg; mul_b = rd_reg;
                        wb_c = asr32(lo, 6'd1);
                    end
                    5'd18: wb_d = asr32(rb_reg + rc_reg, 6'd10);
                    5'd19: begin
                        op = OP_MUL; mul_a = rd_reg; mul_b = 32'd1000;
                        wb_d = asr32(lo, 6'd12);
                    end
                    default: begin
                        fin = 1'b1;
                        if (rd_reg[31]) begin
                            res_value = 33'd0;
                        end else if (rd_reg > 32'd100000) begin
                            res_value = 33'd100000;
                        end else begin
                            res_value = {1'b0, rd_reg};
                        end
                    end
                endcase
            end
            default: fin = 1'b1;
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd_next     = cmd_reg;
        adc_next     = adc_reg;
        fine_next    = fine_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        rc_next      = rc_reg;
        rd_next      = rd_reg;
        re_next      = re_reg;
        big_next     = big_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_value_next = m_value_reg;
        m_fault_next = m_fault_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        commit       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    adc_next   = s_raw_adc;
                    step_next  = 5'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                case (op)
                    OP_MUL: begin
                        mul_start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    OP_DIV: begin
                        div_start  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    default: commit = !fin || out_free;
                endcase
            end
            ST_WAIT: begin
                if ((op == OP_MUL && mul_done) || (op == OP_DIV && div_done)) begin
                    commit     = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (commit) begin
            fine_next = wb_fine;
            ra_next   = wb_a;
            rb_next   = wb_b;
            rc_next   = wb_c;
            rd_next   = wb_d;
            re_next   = wb_e;
            big_next  = wb_big;
            step_next = step_reg + 5'd1;
            if (fin) begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                m_kind_next  = cmd_reg;
                m_value_next = res_value;
                m_fault_next = res_fault;
            end
        end
    end

    assign cfg_index = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= 5'd0;
            fine_reg        <= 32'd0;
            m_valid_reg     <= 1'b0;
            temp_coeffs_reg <= 40'd0;
            press_a_reg     <= 56'd0;
            press_b_reg     <= 64'd0;
            press_ten_reg   <= 8'd0;
            hum_coeffs_reg  <= 64'd0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            fine_reg    <= fine_next;
            m_valid_reg <= m_valid_next;
            if (psel && penable && pwrite) begin
                case (cfg_index)
                    REG_TEMP:     temp_coeffs_reg <= pwdata[39:0];
                    REG_PRESS_A:  press_a_reg     <= pwdata[55:0];
                    REG_PRESS_B:  press_b_reg     <= pwdata;
                    REG_PRESS_10: press_ten_reg   <= pwdata[7:0];
                    REG_HUM:      hum_coeffs_reg  <= pwdata;
                    default: ;
                endcase
            end
        end
        cmd_reg     <= cmd_next;
        adc_reg     <= adc_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        rc_reg      <= rc_next;
        rd_reg      <= rd_next;
        re_reg      <= re_next;
        big_reg     <= big_next;
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_fault_reg <= m_fault_next;
    end

    always_comb begin
        case (cfg_index)
            REG_TEMP:     prdata = {24'd0, temp_coeffs_reg};
            REG_PRESS_A:  prdata = {8'd0, press_a_reg};
            REG_PRESS_B:  prdata = press_b_reg;
            REG_PRESS_10: prdata = {56'd0, press_ten_reg};
            REG_HUM:      prdata = hum_coeffs_reg;
            default:      prdata = 64'd0;
        endcase
    end

    assign pready         = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_value        = $signed(m_value_reg);
    assign m_divide_fault = m_fault_reg;

endmodule

[rtl/esc_checker.sv]
// ----------------------------------------------------------------------------
// Environmental sensor compensation checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_macros.svh"

module esc_checker import esc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_kind,
    input logic signed [32:0] m_value,
    input logic               m_divide_fault
);

    `ESC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_kind))
    `ESC_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ESC_ASSERT_IMP(a_fault_zero, aclk, aresetn, m_valid && m_divide_fault, m_kind == CMD_PRESS && m_value == 33'sd0)
    `ESC_ASSERT_IMP(a_hum_range, aclk, aresetn, m_valid && m_kind == CMD_HUM, !m_value[32] && m_value[31:0] <= 32'd100000)
    `ESC_ASSERT_IMP(a_temp_sext, aclk, aresetn, m_valid && m_kind == CMD_TEMP, m_value[32:16] == {17{m_value[15]}})

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);
